// ----- rtl/lbs_pkg.sv -----
// Shared types and constants of the load balance selector.
`default_nettype none

package lbs_pkg;

  localparam int MAX_POOL_DEF    = 16;
  localparam int METRIC_BITS_DEF = 32;

  // Fixed widths of the ports
  localparam int IN_METRIC_W = 32;
  localparam int SERVER_W    = 4;
  localparam int POOL_W      = 5;
  localparam int CFG_W       = 5;

  typedef enum logic [1:0] {
    REQ_UPDATE   = 2'd0,
    REQ_SELECT   = 2'd1,
    REQ_RR_CLEAR = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STRAT_RANDOM     = 2'd0,
    STRAT_ROUND      = 2'd1,
    STRAT_LEAST_CONN = 2'd2,
    STRAT_LEAST_LAT  = 2'd3
  } strat_t;

  typedef enum logic {
    CFG_STRATEGY = 1'b0,
    CFG_POOL_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_RR   = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  // Broadcast control from the sequencer to every cell of the row
  typedef struct packed {
    logic                wr_en;
    logic [SERVER_W-1:0] wr_idx;
    logic                lat_mode;
    logic [POOL_W-1:0]   live;
  } lbs_cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lbs_cell.sv -----
// One server cell: holds its metrics and passes the running minimum on.
`default_nettype none

module lbs_cell
  import lbs_pkg::*;
#(
  parameter int IDX = 0,
  parameter int MW  = 32,
  parameter int IW  = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  lbs_cell_ctl_t ctl,
  input  logic [MW-1:0] wr_pending,
  input  logic [MW-1:0] wr_latency,
  input  logic          wr_completed,
  input  logic          found_in,
  input  logic [MW-1:0] best_in,
  input  logic [IW-1:0] idx_in,
  output logic          found_out,
  output logic [MW-1:0] best_out,
  output logic [IW-1:0] idx_out
);

  logic [MW-1:0] pending;
  logic [MW-1:0] latency;
  logic          completed;
  logic          hit;
  logic          member;
  logic          skip;
  logic [MW-1:0] metric;
  logic          take;

  assign hit    = ctl.wr_en && ({4'b0, ctl.wr_idx} == 8'(IDX));
  assign member = {4'b0, ctl.live} > 9'(IDX);
  assign skip   = ctl.lat_mode && (latency == '0) && !completed;
  assign metric = ctl.lat_mode ? latency : pending;
  assign take   = member && !skip && (!found_in || (metric < best_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      latency   <= '0;
      completed <= 1'b0;
    end else if (hit) begin
      pending   <= wr_pending;
      latency   <= wr_latency;
      completed <= wr_completed;
    end
  end

  // Advance the running minimum by one cell per cycle
  always_ff @(posedge clk) begin
    found_out <= found_in || take;
    best_out  <= take ? metric : best_in;
    idx_out   <= take ? IW'(IDX) : idx_in;
  end

endmodule

`default_nettype wire

// ----- rtl/lbs_mod.sv -----
// Serial remainder unit: one dividend bit per cycle.
`default_nettype none

module lbs_mod
  import lbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [IN_METRIC_W-1:0] dividend,
  input  logic [POOL_W-1:0]      divisor,
  output logic                   done,
  output logic [POOL_W-1:0]      rem
);

  localparam int CNT_W = $clog2(IN_METRIC_W);

  logic                   run;
  logic [CNT_W-1:0]       cnt;
  logic [IN_METRIC_W-1:0] dvd;
  logic [POOL_W:0]        shifted;
  logic [POOL_W:0]        rem_next;

  assign shifted  = {rem, dvd[IN_METRIC_W-1]};
  assign rem_next = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNT_W'(IN_METRIC_W - 1);
        dvd <= dividend;
        rem <= '0;
      end else if (run) begin
        rem <= POOL_W'(rem_next);
        dvd <= dvd << 1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/load_balance_selector.sv -----
// Load balance selector: sequencer, configuration and a row of server cells.
//
// Use: configuration is written through cfg_we/cfg_idx/cfg_data (index 0
// strategy, index 1 pool size) while the block is idle. An item is taken at
// a rising edge with start high and busy low. Update items write one
// server's metrics at that edge; update, round-robin clear and unused items
// give no result and leave busy low, so another item may follow at once.
// A select item gives one result: chosen_index with done high for exactly
// one cycle; the receiver cannot stall and must take it then.
// Result of a select, by strategy:
//   empty pool: result in the next cycle, busy stays low;
//   round robin: result in the next cycle, then busy while the serial
//     remainder unit works out the advanced index;
//   random: result once the remainder unit has made its 32 remainder steps;
//   least connections / latency: result once the running minimum has
//     crossed the row of MAX_POOL cells.
// Reset (rst, synchronous) clears configuration, the round-robin index and
// every cell's metrics; the block is idle afterwards.
`default_nettype none

module load_balance_selector
  import lbs_pkg::*;
#(
  parameter int MAX_POOL    = MAX_POOL_DEF,
  parameter int METRIC_BITS = METRIC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_idx,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type,
  input  logic [SERVER_W-1:0]    server_index,
  input  logic [IN_METRIC_W-1:0] in_flight,
  input  logic [IN_METRIC_W-1:0] mean_latency,
  input  logic                   has_completed,
  input  logic [IN_METRIC_W-1:0] rnd_word,
  output logic                   done,
  output logic [SERVER_W-1:0]    chosen_index
);

  localparam int MW     = (METRIC_BITS < IN_METRIC_W) ? METRIC_BITS : IN_METRIC_W;
  localparam int IW     = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int SCAN_W = $clog2(MAX_POOL + 1);

  state_t              state;
  strat_t              strategy;
  logic [POOL_W-1:0]   pool_len;
  logic [POOL_W-1:0]   live;
  logic [SERVER_W-1:0] rr_index;
  logic [SCAN_W-1:0]   scan_cnt;
  logic                accept;
  logic                sel;
  logic                mod_go;
  logic                mod_done;
  logic [POOL_W-1:0]   mod_rem;
  logic [IN_METRIC_W-1:0] mod_dividend;
  logic [MW-1:0]       pend_sat;
  logic [MW-1:0]       lat_sat;
  lbs_cell_ctl_t       ctl;

  logic          found_link [MAX_POOL+1];
  logic [MW-1:0] best_link  [MAX_POOL+1];
  logic [IW-1:0] idx_link   [MAX_POOL+1];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign sel    = accept && (req_t'(req_type) == REQ_SELECT);
  assign live   = ({4'b0, pool_len} > 9'(MAX_POOL)) ? POOL_W'(MAX_POOL) : pool_len;

  assign mod_go = sel && (live != '0) &&
                  ((strategy == STRAT_RANDOM) || (strategy == STRAT_ROUND));
  assign mod_dividend = (strategy == STRAT_ROUND) ?
                        IN_METRIC_W'({1'b0, rr_index} + 5'd1) : rnd_word;

  // Saturate to the stored metric width
  assign pend_sat = ((in_flight >> MW) != '0)    ? '1 : MW'(in_flight);
  assign lat_sat  = ((mean_latency >> MW) != '0) ? '1 : MW'(mean_latency);

  assign ctl.wr_en    = accept && (req_t'(req_type) == REQ_UPDATE);
  assign ctl.wr_idx   = server_index;
  assign ctl.lat_mode = (strategy == STRAT_LEAST_LAT);
  assign ctl.live     = live;

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= STRAT_RANDOM;
      pool_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_STRATEGY: strategy <= strat_t'(cfg_data[1:0]);
        CFG_POOL_LEN: pool_len <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rr_index <= '0;
      done     <= 1'b0;
      scan_cnt <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (req_t'(req_type) == REQ_RR_CLEAR)) begin
            rr_index <= '0;
          end
          if (sel) begin
            if (live == '0) begin
              done         <= 1'b1;
              chosen_index <= '0;
            end else begin
              unique case (strategy)
                STRAT_RANDOM: state <= S_MOD;
                STRAT_ROUND: begin
                  done         <= 1'b1;
                  chosen_index <= rr_index;
                  state        <= S_RR;
                end
                STRAT_LEAST_CONN, STRAT_LEAST_LAT: begin
                  scan_cnt <= '0;
                  state    <= S_SCAN;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            done         <= 1'b1;
            chosen_index <= SERVER_W'(mod_rem);
            state        <= S_IDLE;
          end
        end
        S_RR: begin
          if (mod_done) begin
            rr_index <= SERVER_W'(mod_rem);
            state    <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Read the tail once the head value has crossed the whole row
          if (scan_cnt == SCAN_W'(MAX_POOL)) begin
            done         <= 1'b1;
            chosen_index <= found_link[MAX_POOL] ? SERVER_W'(idx_link[MAX_POOL]) : '0;
            state        <= S_IDLE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lbs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (mod_go),
    .dividend (mod_dividend),
    .divisor  (live),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign found_link[0] = 1'b0;
  assign best_link[0]  = '0;
  assign idx_link[0]   = '0;

  for (genvar i = 0; i < MAX_POOL; i++) begin : g_cell
    lbs_cell #(
      .IDX (i),
      .MW  (MW),
      .IW  (IW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .wr_pending   (pend_sat),
      .wr_latency   (lat_sat),
      .wr_completed (has_completed),
      .found_in     (found_link[i]),
      .best_in      (best_link[i]),
      .idx_in       (idx_link[i]),
      .found_out    (found_link[i+1]),
      .best_out     (best_link[i+1]),
      .idx_out      (idx_link[i+1])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/lbs_checker.sv -----
// Port-level checks of the load balance selector, bound to the top level.
`default_nettype none

module lbs_checker
  import lbs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       done
);

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !busy && !done)
    else $error("block not idle after reset");

  // Items other than select never occupy the block or give a result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_UPDATE || req_type == REQ_RR_CLEAR ||
                        req_type == REQ_NONE)) |=> !busy && !done)
    else $error("non-select beat produced work or a result");

  // A result only follows an accepted beat or work in progress
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a cause");

  // A select on an idle block either answers or goes busy in the next cycle
  a_select_reacts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_SELECT) |=> done || busy)
    else $error("select beat ignored");

endmodule

bind load_balance_selector lbs_checker u_lbs_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench of load_balance_selector: directed table, then random phases.
module tb;
  import lbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSRV   = MAX_POOL_DEF;
  localparam int SETTLE = 40;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 140;

  typedef struct {
    req_t        req;
    logic [3:0]  srv;
    logic [31:0] inf;
    logic [31:0] lat;
    logic        comp;
    logic [31:0] rnd;
  } lb_item_t;

  typedef struct {
    bit         is_cfg;
    logic [4:0] strat_data;
    logic [4:0] pool_data;
    lb_item_t   it;
    bit         typed;
    logic [3:0] want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic                   cfg_idx = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             req_type = '0;
  logic [SERVER_W-1:0]    server_index = '0;
  logic [IN_METRIC_W-1:0] in_flight = '0;
  logic [IN_METRIC_W-1:0] mean_latency = '0;
  logic                   has_completed = 1'b0;
  logic [IN_METRIC_W-1:0] rnd_word = '0;
  logic                   done;
  logic [SERVER_W-1:0]    chosen_index;

  load_balance_selector DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .req_type(req_type), .server_index(server_index),
    .in_flight(in_flight), .mean_latency(mean_latency),
    .has_completed(has_completed), .rnd_word(rnd_word),
    .done(done), .chosen_index(chosen_index)
  );

  always #5 clk = ~clk;

  // Shadow of the block's configuration and server metrics
  strat_t      sh_strat = STRAT_RANDOM;
  logic [4:0]  sh_pool = '0;
  logic [3:0]  sh_rr = '0;
  logic [31:0] sh_pending [NSRV];
  logic [31:0] sh_latency [NSRV];
  logic        sh_completed [NSRV];

  logic [3:0]  picks_due [$];
  stim_row_t   table_rows [$];
  int          errors = 0;
  int          idle_pct = 0;

  initial begin
    for (int i = 0; i < NSRV; i++) begin
      sh_pending[i] = '0;
      sh_latency[i] = '0;
      sh_completed[i] = 1'b0;
    end
  end

  // Work out the effect of one accepted beat on the shadow state
  task automatic predict_pick(input lb_item_t it, output bit gives, output logic [3:0] pick);
    int n;
    logic [63:0] lo;
    gives = 1'b0;
    pick = '0;
    n = (sh_pool > NSRV) ? NSRV : int'(sh_pool);
    case (it.req)
      REQ_UPDATE: begin
        sh_pending[it.srv] = it.inf;
        sh_latency[it.srv] = it.lat;
        sh_completed[it.srv] = it.comp;
      end
      REQ_RR_CLEAR: sh_rr = '0;
      REQ_SELECT: begin
        gives = 1'b1;
        lo = '1;
        if (n != 0) begin
          case (sh_strat)
            STRAT_ROUND: begin
              pick = sh_rr;
              sh_rr = 4'((int'(sh_rr) + 1) % n);
            end
            STRAT_LEAST_CONN: begin
              for (int i = 0; i < n; i++)
                if (64'(sh_pending[i]) < lo) begin
                  lo = 64'(sh_pending[i]);
                  pick = 4'(i);
                end
            end
            STRAT_LEAST_LAT: begin
              for (int i = 0; i < n; i++)
                if (!(sh_latency[i] == '0 && !sh_completed[i]) && 64'(sh_latency[i]) < lo) begin
                  lo = 64'(sh_latency[i]);
                  pick = 4'(i);
                end
            end
            default: pick = 4'(it.rnd % n);
          endcase
        end
      end
      default: ;
    endcase
  endtask

  // Present one beat, optionally after an idle gap, and hold it until taken
  task automatic send_beat(input lb_item_t it, input bit typed, input logic [3:0] want);
    bit gives;
    logic [3:0] pick;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= it.req;
    server_index <= it.srv;
    in_flight <= it.inf;
    mean_latency <= it.lat;
    has_completed <= it.comp;
    rnd_word <= it.rnd;
    do @(posedge clk); while (busy);
    predict_pick(it, gives, pick);
    if (gives) picks_due.push_back(typed ? want : pick);
  endtask

  // Hold off until every pick has come back and the block has settled
  task automatic drain;
    start <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] strat_data, input logic [4:0] pool_data);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_STRATEGY;
    cfg_data <= strat_data;
    @(posedge clk);
    sh_strat = strat_t'(strat_data[1:0]);
    cfg_idx <= CFG_POOL_LEN;
    cfg_data <= pool_data;
    @(posedge clk);
    sh_pool = pool_data;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_metric();
    case ($urandom_range(0, 3))
      0: rand_metric = '0;
      1: rand_metric = 32'($urandom_range(0, 15));
      2: rand_metric = '1;
      default: rand_metric = $urandom;
    endcase
  endfunction

  function automatic lb_item_t rand_item();
    lb_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.req = (r < 55) ? REQ_UPDATE : (r < 90) ? REQ_SELECT : (r < 95) ? REQ_RR_CLEAR : REQ_NONE;
    it.srv = 4'($urandom_range(0, 15));
    it.inf = rand_metric();
    it.lat = rand_metric();
    it.comp = 1'($urandom_range(0, 1));
    it.rnd = $urandom;
    return it;
  endfunction

  function automatic lb_item_t mk_item(req_t req, logic [3:0] srv, logic [31:0] inf,
                                       logic [31:0] lat, logic comp, logic [31:0] rnd);
    lb_item_t it;
    it.req = req;
    it.srv = srv;
    it.inf = inf;
    it.lat = lat;
    it.comp = comp;
    it.rnd = rnd;
    return it;
  endfunction

  task automatic add_cfg(input strat_t s, input logic [4:0] pool);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.strat_data = {3'b000, s};
    row.pool_data = pool;
    row.it = mk_item(REQ_NONE, '0, '0, '0, 1'b0, '0);
    row.typed = 1'b0;
    row.want = '0;
    table_rows.push_back(row);
  endtask

  task automatic add_row(input lb_item_t it, input bit typed, input logic [3:0] want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.strat_data = '0;
    row.pool_data = '0;
    row.it = it;
    row.typed = typed;
    row.want = want;
    table_rows.push_back(row);
  endtask

  task automatic add_select(input logic [31:0] rnd, input bit typed, input logic [3:0] want);
    add_row(mk_item(REQ_SELECT, 4'hA, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, rnd), typed, want);
  endtask

  // Compare every strobed pick with the oldest one due
  always @(posedge clk) begin
    if (!rst && done) begin
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected pick: expected none, got %0d", $time, chosen_index);
        errors++;
      end else begin
        if (chosen_index !== picks_due[0]) begin
          $display("%0t: chosen_index mismatch: expected %0d, got %0d",
                   $time, picks_due[0], chosen_index);
          errors++;
        end
        void'(picks_due.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [4:0] pool;
    // Empty pool after reset, then round robin on an empty pool
    add_select('1, 1'b1, 4'd0);
    add_cfg(STRAT_ROUND, 5'd0);
    add_select('0, 1'b1, 4'd0);
    add_cfg(STRAT_RANDOM, 5'd16);
    add_select('1, 1'b1, 4'd15);
    add_select('0, 1'b1, 4'd0);
    // Oversized pool is clamped to the full row
    add_cfg(STRAT_RANDOM, 5'd31);
    add_select(32'h1234_5677, 1'b1, 4'd7);
    add_cfg(STRAT_ROUND, 5'd3);
    add_select($urandom, 1'b1, 4'd0);
    add_select($urandom, 1'b1, 4'd1);
    add_select($urandom, 1'b1, 4'd2);
    add_select($urandom, 1'b1, 4'd0);
    add_row(mk_item(REQ_RR_CLEAR, 4'hF, '1, '1, 1'b1, '1), 1'b0, '0);
    add_row(mk_item(REQ_NONE, 4'h5, '1, '0, 1'b1, '1), 1'b0, '0);
    add_select($urandom, 1'b1, 4'd0);
    add_cfg(STRAT_ROUND, 5'd16);
    add_select($urandom, 1'b1, 4'd1);
    // Shrink the pool under the index: stale index comes back as is
    add_cfg(STRAT_ROUND, 5'd2);
    add_select($urandom, 1'b1, 4'd2);
    add_select($urandom, 1'b1, 4'd1);
    add_cfg(STRAT_LEAST_CONN, 5'd16);
    add_row(mk_item(REQ_UPDATE, 4'd0, '1, '1, 1'b1, '0), 1'b0, '0);
    add_row(mk_item(REQ_UPDATE, 4'd15, '0, '0, 1'b0, '1), 1'b0, '0);
    add_select($urandom, 1'b0, '0);
    add_cfg(STRAT_LEAST_LAT, 5'd16);
    add_select($urandom, 1'b0, '0);
    // Zero latency counts only once the server has completed a request
    add_row(mk_item(REQ_UPDATE, 4'd9, 32'd5, '0, 1'b1, '0), 1'b0, '0);
    add_select($urandom, 1'b0, '0);
    add_row(mk_item(REQ_UPDATE, 4'd9, 32'd5, '0, 1'b0, '0), 1'b0, '0);
    add_select($urandom, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain();
        set_config(table_rows[i].strat_data, table_rows[i].pool_data);
      end else begin
        send_beat(table_rows[i].it, table_rows[i].typed, table_rows[i].want);
      end
    end

    for (int k = 0; k < PHASES; k++) begin
      drain();
      case (k % 4)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      if (k < 4) begin
        pool = (k == 1) ? 5'd31 : 5'd16;
        set_config({3'($urandom_range(0, 7)), 2'(k)}, pool);
      end else begin
        pool = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 1))
                                           : 5'($urandom_range(2, 31));
        set_config(5'($urandom_range(0, 31)), pool);
      end
      repeat (PHASE_ITEMS) send_beat(rand_item(), 1'b0, '0);
    end

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
